// File: sv/utf8_text_validator_macros.svh
`ifndef UTF8_TEXT_VALIDATOR_MACROS_SVH
`define UTF8_TEXT_VALIDATOR_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define UTV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("utf8 validator check failed");

// next-cycle implication
`define UTV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("utf8 validator check failed");

`endif

// File: sv/utv_pkg.sv
package utv_pkg;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_CTRL  = 3'd1,
        ERR_LEAD  = 3'd2,
        ERR_CONT  = 3'd3,
        ERR_RANGE = 3'd4,
        ERR_TRUNC = 3'd5
    } t_err;

    typedef enum logic [2:0] {
        RULE_NONE = 3'd0,
        RULE_E0   = 3'd1,
        RULE_ED   = 3'd2,
        RULE_F0   = 3'd3,
        RULE_F4   = 3'd4
    } t_rule;

    typedef struct packed {
        logic text_ok;
        t_err error_kind;
        logic final_res;
    } t_result;

    localparam logic [7:0] C_TAB     = 8'h09;
    localparam logic [7:0] C_LF      = 8'h0a;
    localparam logic [7:0] C_CR      = 8'h0d;
    localparam logic [7:0] C_SPACE   = 8'h20;
    localparam logic [7:0] C_DEL     = 8'h7f;
    localparam logic [7:0] C_ASCII   = 8'h80;
    localparam logic [7:0] C_L2_LO   = 8'hc2;
    localparam logic [7:0] C_L2_HI   = 8'hdf;
    localparam logic [7:0] C_L3_LO   = 8'he0;
    localparam logic [7:0] C_L3_HI   = 8'hef;
    localparam logic [7:0] C_L4_LO   = 8'hf0;
    localparam logic [7:0] C_L4_HI   = 8'hf4;
    localparam logic [7:0] C_LEAD_ED = 8'hed;
    localparam logic [7:0] C_A0      = 8'ha0;
    localparam logic [7:0] C_90      = 8'h90;
    localparam logic [1:0] C_CONT_TAG = 2'b10;

endpackage

// File: sv/utf8_text_validator.sv
// a result is registered into the output word, or into the skid word while the output word is stalled
// throughput: one byte per cycle while o_stall is low; a two-word output stage absorbs a stalled result
// o_stall rises only when both output words are held by downstream stall
// reset (i_rst_n low, synchronous) clears sequence state, sticky error and output valids
module utf8_text_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_text_ok,
    output logic [2:0] o_error_kind,
    output logic       o_final_res
);
    import utv_pkg::*;

    logic [1:0] r_pend, n_pend;
    t_rule      r_rule, n_rule;
    t_err       r_err,  n_err;

    logic       r_out_valid, r_skid_valid;
    t_result    r_out, r_skid;
    t_result    w_res;
    t_err       w_e;
    logic       w_range_ok;
    logic       w_accept, w_out_free;

    assign w_accept   = i_valid && !r_skid_valid;
    assign w_out_free = !r_out_valid || !i_stall;

    // per-byte check
    always_comb begin
        n_pend     = r_pend;
        n_rule     = r_rule;
        w_e        = ERR_NONE;
        w_range_ok = 1'b1;
        if (r_err == ERR_NONE) begin
            if (r_pend != 2'd0) begin
                case (r_rule)
                    RULE_E0: w_range_ok = (i_data_byte >= C_A0);
                    RULE_ED: w_range_ok = (i_data_byte <  C_A0);
                    RULE_F0: w_range_ok = (i_data_byte >= C_90);
                    RULE_F4: w_range_ok = (i_data_byte <  C_90);
                    default: w_range_ok = 1'b1;
                endcase
                if (i_data_byte[7:6] != C_CONT_TAG) begin
                    w_e = ERR_CONT;
                end else if (!w_range_ok) begin
                    w_e = ERR_RANGE;
                end else begin
                    n_rule = RULE_NONE;
                    n_pend = r_pend - 2'd1;
                end
            end else if (i_data_byte < C_ASCII) begin
                if ((i_data_byte < C_SPACE && !(i_data_byte inside {C_TAB, C_LF, C_CR}))
                    || i_data_byte == C_DEL) begin
                    w_e = ERR_CTRL;
                end
            end else begin
                if (i_data_byte inside {[C_L2_LO:C_L2_HI]}) begin
                    n_pend = 2'd1;
                end else if (i_data_byte inside {[C_L3_LO:C_L3_HI]}) begin
                    n_pend = 2'd2;
                end else if (i_data_byte inside {[C_L4_LO:C_L4_HI]}) begin
                    n_pend = 2'd3;
                end else begin
                    w_e = ERR_LEAD;
                end
                if (w_e == ERR_NONE) begin
                    case (i_data_byte)
                        C_L3_LO:   n_rule = RULE_E0;
                        C_LEAD_ED: n_rule = RULE_ED;
                        C_L4_LO:   n_rule = RULE_F0;
                        C_L4_HI:   n_rule = RULE_F4;
                        default:   n_rule = RULE_NONE;
                    endcase
                end
            end
            if (w_e == ERR_NONE && i_last_byte && n_pend != 2'd0) begin
                w_e = ERR_TRUNC;
            end
            n_err = w_e;
        end else begin
            n_err = r_err;
        end

        w_res.text_ok    = (n_err == ERR_NONE);
        w_res.error_kind = n_err;
        w_res.final_res  = i_last_byte;

        // buffer closed: start clean
        if (i_last_byte) begin
            n_pend = 2'd0;
            n_rule = RULE_NONE;
            n_err  = ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_rule <= RULE_NONE;
            r_err  <= ERR_NONE;
        end else if (w_accept) begin
            r_pend <= n_pend;
            r_rule <= n_rule;
            r_err  <= n_err;
        end
    end

    // output word plus skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_accept) begin
            r_skid <= w_res;
        end
    end

    assign o_stall      = r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_text_ok    = r_out.text_ok;
    assign o_error_kind = r_out.error_kind;
    assign o_final_res  = r_out.final_res;

endmodule

// File: sv/utv_checker.sv
`include "utf8_text_validator_macros.svh"

module utv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_text_ok,
    input logic [2:0] o_error_kind,
    input logic       o_final_res
);
    import utv_pkg::*;

    logic [2:0] r_stick;
    logic       w_out_take;
    logic [4:0] w_word;

    assign w_out_take = o_valid && !i_stall;
    assign w_word     = {o_text_ok, o_error_kind, o_final_res};

    // error kind delivered on a word that did not close its buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stick <= ERR_NONE;
        end else if (w_out_take) begin
            r_stick <= o_final_res ? ERR_NONE : o_error_kind;
        end
    end

    `UTV_ASSERT_NOW(a_ok_matches_kind, o_valid, o_text_ok == (o_error_kind == ERR_NONE))
    `UTV_ASSERT_NOW(a_error_sticks, o_valid && r_stick != ERR_NONE, o_error_kind == r_stick)
    `UTV_ASSERT_NOW(a_trunc_only_final, o_valid && o_error_kind == ERR_TRUNC, o_final_res)
    `UTV_ASSERT_NEXT(a_stalled_word_holds, o_valid && i_stall, o_valid && $stable(w_word))

endmodule

bind utf8_text_validator utv_checker u_utv_checker (.*);

// File: tb/sv/utf8_text_validator_test.sv
`timescale 1ns / 100ps

module utf8_text_validator_test;
    import utv_pkg::*;

    localparam int RANDOM_BYTES = 1600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 8;

    typedef struct {
        logic [7:0] value;
        logic       last;
        bit         drain;
    } t_byte_item;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_data_byte  = 8'h00;
    logic       i_last_byte  = 1'b0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_text_ok;
    logic [2:0] o_error_kind;
    logic       o_final_res;

    t_byte_item byte_q[$];
    t_result    verdict_q[$];
    logic [7:0] text_q[$];

    // predictor state
    logic [1:0] pend_cont;
    t_rule      second_rule;
    t_err       sticky_err;

    int total_items   = 0;
    int bytes_offered = 0;
    int bytes_taken   = 0;
    int verdicts_seen = 0;
    int errors        = 0;
    int cycle_cnt     = 0;
    int in_wait       = 0;
    int stall_left    = 0;
    int stall_seen    = 0;
    bit in_calm       = 1'b0;
    bit out_calm      = 1'b0;

    utf8_text_validator uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_text_ok    (o_text_ok),
        .o_error_kind (o_error_kind),
        .o_final_res  (o_final_res)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_verdict_state();
        pend_cont   = 2'd0;
        second_rule = RULE_NONE;
        sticky_err  = ERR_NONE;
    endfunction

    function automatic t_result next_verdict(logic [7:0] b, logic last);
        t_result res;
        t_err    e;
        logic    in_range;
        if (sticky_err == ERR_NONE) begin
            e = ERR_NONE;
            if (pend_cont != 2'd0) begin
                if (b[7:6] != C_CONT_TAG) begin
                    // not re-read as a lead, the sequence is simply broken
                    e = ERR_CONT;
                end else begin
                    case (second_rule)
                        RULE_E0: in_range = b >= C_A0;
                        RULE_ED: in_range = b < C_A0;
                        RULE_F0: in_range = b >= C_90;
                        RULE_F4: in_range = b < C_90;
                        default: in_range = 1'b1;
                    endcase
                    if (!in_range) begin
                        e = ERR_RANGE;
                    end else begin
                        second_rule = RULE_NONE;
                        pend_cont   = pend_cont - 2'd1;
                    end
                end
            end else if (b < C_ASCII) begin
                if ((b < C_SPACE && b != C_TAB && b != C_LF && b != C_CR) || b == C_DEL)
                    e = ERR_CTRL;
            end else if (b >= C_L2_LO && b <= C_L2_HI) begin
                pend_cont   = 2'd1;
                second_rule = RULE_NONE;
            end else if (b >= C_L3_LO && b <= C_L3_HI) begin
                pend_cont   = 2'd2;
                second_rule = (b == C_L3_LO) ? RULE_E0 :
                              (b == C_LEAD_ED) ? RULE_ED : RULE_NONE;
            end else if (b >= C_L4_LO && b <= C_L4_HI) begin
                pend_cont   = 2'd3;
                second_rule = (b == C_L4_LO) ? RULE_F0 :
                              (b == C_L4_HI) ? RULE_F4 : RULE_NONE;
            end else begin
                e = ERR_LEAD;
            end
            if (e == ERR_NONE && last && pend_cont != 2'd0)
                e = ERR_TRUNC;
            sticky_err = e;
        end
        res.text_ok    = (sticky_err == ERR_NONE);
        res.error_kind = sticky_err;
        res.final_res  = last;
        if (last)
            clear_verdict_state();
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    endtask

    // moves the text under construction into the pending words, last one marked
    task automatic flush_text(input bit drain);
        t_byte_item it;
        for (int k = 0; k < text_q.size(); k++) begin
            it.value = text_q[k];
            it.last  = (k == text_q.size() - 1);
            it.drain = drain && (k == 0);
            byte_q.push_back(it);
            total_items++;
        end
        text_q.delete();
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hbf));
    endfunction

    task automatic add_char();
        int         kind;
        int         pick;
        logic [7:0] lead;
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                text_q.push_back(C_TAB);
            else if (pick == 1)
                text_q.push_back(C_LF);
            else if (pick == 2)
                text_q.push_back(C_CR);
            else
                text_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
        end else if (kind <= 5) begin
            text_q.push_back(8'($urandom_range(C_L2_LO, C_L2_HI)));
            text_q.push_back(cont_byte());
        end else if (kind <= 7) begin
            // lean on the leads whose second word is range-limited
            if ($urandom_range(0, 1))
                lead = $urandom_range(0, 1) ? C_L3_LO : C_LEAD_ED;
            else
                lead = 8'($urandom_range(C_L3_LO, C_L3_HI));
            text_q.push_back(lead);
            if (lead == C_L3_LO)
                text_q.push_back(8'($urandom_range(8'ha0, 8'hbf)));
            else if (lead == C_LEAD_ED)
                text_q.push_back(8'($urandom_range(8'h80, 8'h9f)));
            else
                text_q.push_back(cont_byte());
            text_q.push_back(cont_byte());
        end else begin
            if ($urandom_range(0, 1))
                lead = $urandom_range(0, 1) ? C_L4_LO : C_L4_HI;
            else
                lead = 8'($urandom_range(C_L4_LO, C_L4_HI));
            text_q.push_back(lead);
            if (lead == C_L4_LO)
                text_q.push_back(8'($urandom_range(8'h90, 8'hbf)));
            else if (lead == C_L4_HI)
                text_q.push_back(8'($urandom_range(8'h80, 8'h8f)));
            else
                text_q.push_back(cont_byte());
            text_q.push_back(cont_byte());
            text_q.push_back(cont_byte());
        end
    endtask

    // word source: holds a stalled word, then idles a drawn number of cycles
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && bytes_taken != bytes_offered)) begin
            if (in_wait != 0) begin
                i_valid <= 1'b0;
                in_wait--;
            end else if (byte_q.size() == 0 || (byte_q[0].drain && verdict_q.size() != 0)) begin
                i_valid <= 1'b0;
            end else begin
                i_valid     <= 1'b1;
                i_data_byte <= byte_q[0].value;
                i_last_byte <= byte_q[0].last;
                void'(byte_q.pop_front());
                bytes_offered++;
                if ($urandom_range(0, 63) == 0)
                    in_calm = !in_calm;
                in_wait = in_calm ? 0 : $urandom_range(0, 11);
            end
        end
    end

    // result sink: stall drawn afresh after every taken word
    always @(negedge i_clk) begin
        if (verdicts_seen != stall_seen) begin
            stall_seen = verdicts_seen;
            if ($urandom_range(0, 63) == 0)
                out_calm = !out_calm;
            stall_left = out_calm ? 0 : $urandom_range(0, 11);
        end
        if (stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && i_valid && !o_stall) begin
            verdict_q.push_back(next_verdict(i_data_byte, i_last_byte));
            bytes_taken++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            verdicts_seen++;
            if (verdict_q.size() == 0) begin
                flag_mismatch("unexpected word", 1, 0);
            end else begin
                want = verdict_q.pop_front();
                if (o_text_ok !== want.text_ok)
                    flag_mismatch("text_ok", o_text_ok, want.text_ok);
                if (o_error_kind !== want.error_kind)
                    flag_mismatch("error_kind", o_error_kind, want.error_kind);
                if (o_final_res !== want.final_res)
                    flag_mismatch("final_res", o_final_res, want.final_res);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int start_items;
        int n_texts;
        int mode;
        int pos;
        int len;
        clear_verdict_state();

        // plain ascii with the allowed controls
        text_q = '{8'h41, C_TAB, C_LF, C_CR, 8'h7e};
        flush_text(1'b0);
        text_q = '{8'h00};
        flush_text(1'b0);
        text_q = '{C_DEL};
        flush_text(1'b0);
        text_q = '{8'hff};
        flush_text(1'b0);
        text_q = '{C_L2_LO, 8'h80};
        flush_text(1'b0);
        // overlong three-word form, error held over the next word
        text_q = '{C_L3_LO, 8'h9f, 8'h80};
        flush_text(1'b0);
        // surrogate
        text_q = '{C_LEAD_ED, 8'ha0, 8'h80};
        flush_text(1'b0);
        // above the last code point
        text_q = '{C_L4_HI, 8'h90, 8'h80, 8'h80};
        flush_text(1'b0);
        // broken continuation, not taken as a new lead
        text_q = '{C_L2_HI, 8'h41};
        flush_text(1'b0);
        // second word not a continuation, though within the E0 range: continuation error
        text_q = '{C_L3_LO, 8'hc0};
        flush_text(1'b0);
        // sequence still open at the last word
        text_q = '{C_L4_LO, 8'h90};
        flush_text(1'b0);

        start_items = total_items;
        n_texts = 0;
        while (total_items - start_items < RANDOM_BYTES) begin
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    add_char();
                if (mode == 1) begin
                    pos = $urandom_range(0, text_q.size() - 1);
                    text_q[pos] = 8'($urandom_range(0, 255));
                end else if (mode == 2) begin
                    len = $urandom_range(1, 2);
                    for (int k = 0; k < len; k++)
                        if (text_q.size() > 1)
                            void'(text_q.pop_back());
                end
            end
            flush_text(n_texts % 50 == 0);
            n_texts++;
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken != total_items)
            @(posedge i_clk);
        while (verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
